// ===== rtl/skmc_pkg.sv =====
// skmc_pkg: shared types, constants and spacer pattern tables
// for the spacer k-mer mismatch counter; no dependencies

package skmc_pkg;

   // fixed field widths
   localparam int LEN_W     = 10;
   localparam int THR_W     = 16;
   localparam int IDX_W     = 6;
   localparam int BASE_W    = 3;
   localparam int DIGIT_W   = 3;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;

   // parameter defaults
   localparam int DEF_NUM_SPACERS  = 43;
   localparam int DEF_PATTERN_LEN  = 25;
   localparam int DEF_COUNT_WIDTH  = 32;
   localparam int DEF_MAX_READ_LEN = 1000;

   // register reset values
   localparam logic [LEN_W-1:0] READ_LENGTH_RST = 10'd75;
   localparam logic [THR_W-1:0] THRESHOLD_RST   = 16'd4;

   // register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_READ_LENGTH = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_THRESHOLD   = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_ORIENTATION = 2'd2;

   // base codes
   localparam logic [BASE_W-1:0] BASE_OTHER = 3'd4;
   localparam logic [BASE_W-1:0] CODE_NONE  = 3'd7;

   // pending counters always hold a whole read
   localparam int PEND_W = 10;

   // table geometry
   localparam int TAB_ROWS = 43;
   localparam int TAB_COLS = 25;

   typedef logic [BASE_W-1:0] base_type;

   // per-item control handed from the front stage to the cells
   typedef struct packed {
      logic cmp;
      logic commit;
      logic clear;
      logic report;
   } ctl_type;

   localparam logic [8*TAB_COLS-1:0] DIR_PAT [TAB_ROWS] = '{
      "ATAGAGGGTCGCCGGCTCTGGATCA", "CCTCATGCTTGGGCGACAGCTTTTG",
      "CCGTGCTTCCAGTGATCGCCTTCTA", "ACGTCATACGCCGACCAATCATCAG",
      "TTTTCTGACCACTTGTGCGGGATTA", "CGTCGTCATTTCCGGCTTCAATTTC",
      "GAGGAGAGCGAGTACTCGGGGCTGC", "CGTGAAACCGCCCCCAGCCTCGCCG",
      "ACTCGGAATCCCATGTGCTGACAGC", "TCGACACCCGCTCTAGTTGACTTCC",
      "GTGAGCAACGGCGGCGGCAACCTGG", "ATATCTGCTGCCCGCCCGGGGAGAT",
      "GACCATCATTGCCATTCCCTCTCCC", "GGTGTGATGCGGATGGTCGGCTCGG",
      "CTTGAATAACGCGCAGTGAATTTCG", "CGAGTTCCCGTCAGCGTCGTAAATC",
      "GCGCCGGCCCGCGCGGATGACTCCG", "CATGGACCCGGGCGAGCTGCAGATG",
      "TAACTGGCTTGGCGCTGATCCTGGT", "TTGACCTCGCCAGGAGAGAAGATCA",
      "TCGATGTCGATGTCCCAATCGTCGA", "ACCGCAGACGGCACGATTGAGACAA",
      "AGCATCGCTGATGCGGTCCAGCTCG", "CCGCCTGCTGGGTGAGACGTGCTCG",
      "GATCAGCGACCACCGCACCCTGTCA", "CTTCAGCACCACCATCATCCGGCGC",
      "GGATTCGTGATCTCTTCCCGCGGAT", "TGCCCCGGCGTTTAGCGATCACAAC",
      "AAATACAGGCTCCACGACACGACCA", "GGTTGCCCCGCGCCCTTTTCCAGCC",
      "TCAGACAGGTTCGCGTCGATCAAGT", "GACCAAATAGGTATCGGCGTGTTCA",
      "GACATGACGGCGGTGCCGCACTTGA", "AAGTCACCTCGCCCACACCGTCGAA",
      "TCCGTACGCTCGAAACGCTTCCAAC", "CGAAATCCAGCACCACATCCGCAGC",
      "CGCGAACTCGTCCACAGTCCCCCTT", "CGTGGATGGCGGATGCGTTGTGCGC",
      "GACGATGGCCAGTAAATCGGCGTGG", "CGCCATCTGTGCCTCATACAGGTCC",
      "GGAGCTTTCCGGCTTCTATCAGGTA", "ATGGTGGGACATGGACGAGCGCGAC",
      "CGCAGAATCGCACCGGGTGCGGGAG"
   };

   localparam logic [8*TAB_COLS-1:0] REV_PAT [TAB_ROWS] = '{
      "TGATCCAGAGCCGGCGACCCTCTAT", "CAAAAGCTGTCGCCCAAGCATGAGG",
      "TAGAAGGCGATCACTGGAAGCACGG", "CTGATGATTGGTCGGCGTATGACGT",
      "TAATCCCGCACAAGTGGTCAGAAAA", "GAAATTGAAGCCGGAAATGACGACG",
      "GCAGCCCCGAGTACTCGCTCTCCTC", "CGGCGAGGCTGGGGGCGGTTTCACG",
      "GCTGTCAGCACATGGGATTCCGAGT", "GGAAGTCAACTAGAGCGGGTGTCGA",
      "CCAGGTTGCCGCCGCCGTTGCTCAC", "ATCTCCCCGGGCGGGCAGCAGATAT",
      "GGGAGAGGGAATGGCAATGATGGTC", "CCGAGCCGACCATCCGCATCACACC",
      "CGAAATTCACTGCGCGTTATTCAAG", "GATTTACGACGCTGACGGGAACTCG",
      "CGGAGTCATCCGCGCGGGCCGGCGC", "CATCTGCAGCTCGCCCGGGTCCATG",
      "ACCAGGATCAGCGCCAAGCCAGTTA", "TGATCTTCTCTCCTGGCGAGGTCAA",
      "TCGACGATTGGGACATCGACATCGA", "TTGTCTCAATCGTGCCGTCTGCGGT",
      "CGAGCTGGACCGCATCAGCGATGCT", "CGAGCACGTCTCACCCAGCAGGCGG",
      "TGACAGGGTGCGGTGGTCGCTGATC", "GCGCCGGATGATGGTGGTGCTGAAG",
      "ATCCGCGGGAAGAGATCACGAATCC", "GTTGTGATCGCTAAACGCCGGGGCA",
      "TGGTCGTGTCGTGGAGCCTGTATTT", "GGCTGGAAAAGGGCGCGGGGCAACC",
      "ACTTGATCGACGCGAACCTGTCTGA", "TGAACACGCCGATACCTATTTGGTC",
      "TCAAGTGCGGCACCGCCGTCATGTC", "TTCGACGGTGTGGGCGAGGTGACTT",
      "GTTGGAAGCGTTTCGAGCGTACGGA", "GCTGCGGATGTGGTGCTGGATTTCG",
      "AAGGGGGACTGTGGACGAGTTCGCG", "GCGCACAACGCATCCGCCATCCACG",
      "CCACGCCGATTTACTGGCCATCGTC", "GGACCTGTATGAGGCACAGATGGCG",
      "TACCTGATAGAAGCCGGAAAGCTCC", "GTCGCGCTCGTCCATGTCCCACCAT",
      "CTCCCGCACCCGGTGCGATTCTGCG"
   };

   // base code of one pattern position; positions past the table never match
   function automatic base_type pattern_code(input int s, input int j, input logic rev);
      logic [7:0] ch;
      base_type   code;
      code = CODE_NONE;
      ch   = 8'h00;
      if (s < TAB_ROWS && j < TAB_COLS) begin
         ch = rev ? REV_PAT[s][8*(TAB_COLS-1-j) +: 8] : DIR_PAT[s][8*(TAB_COLS-1-j) +: 8];
      end
      case (ch)
         "A":     code = 3'd0;
         "C":     code = 3'd1;
         "G":     code = 3'd2;
         "T":     code = 3'd3;
         default: code = CODE_NONE;
      endcase
      return code;
   endfunction

endpackage

// ===== rtl/spacer_kmer_mismatch_counter.sv =====
// spacer_kmer_mismatch_counter: top level with window, read position
// tracking, cell row and report output; depends on skmc_pkg, skmc_cell

// Takes one read base per cycle. Each base enters a register stage that
// shifts the window and works out the read position, then the row of
// spacer cells compares the window and updates pending and total counts
// in the next cycle. A report item snapshots all totals into the cells'
// shift chain in the cycle after it is taken and then yields one result
// per spacer, one per cycle while rsp_tready is high, spacer 0 first.
// Bases keep flowing while a report drains; a second report waits until
// the chain has emptied.

module spacer_kmer_mismatch_counter #(
   parameter int NUM_SPACERS  = skmc_pkg::DEF_NUM_SPACERS,
   parameter int PATTERN_LEN  = skmc_pkg::DEF_PATTERN_LEN,
   parameter int COUNT_WIDTH  = skmc_pkg::DEF_COUNT_WIDTH,
   parameter int MAX_READ_LEN = skmc_pkg::DEF_MAX_READ_LEN,
   localparam int RSP_BITS    = skmc_pkg::IDX_W + 2*COUNT_WIDTH + 5,
   localparam int RSP_W       = ((RSP_BITS + 7) / 8) * 8
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,   // base[2:0]
   input  logic                            req_tuser,   // command
   input  logic                            req_tlast,   // read_end
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // spacer_index, exact_count, near_count, present, octal_digit, digit_valid
   output logic [RSP_W-1:0]                rsp_tdata,
   output logic                            rsp_tlast,   // last
   input  logic                            csr_we,
   input  logic [skmc_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [skmc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import skmc_pkg::*;

   localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_READ_LEN);
   localparam logic [LEN_W-1:0] PLEN    = LEN_W'(PATTERN_LEN);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_SPACERS - 1);

   logic [LEN_W-1:0] rlen_ff;
   logic [THR_W-1:0] thr_ff;
   logic             orient_ff;

   base_type         win_ff [PATTERN_LEN];
   base_type         new_base;
   logic [LEN_W-1:0] pos_ff, pos_in, pos_n, len;
   ctl_type          ctl_ff, ctl_in;
   logic             accept, busy_ff, busy_in, shift;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [1:0]       grp_ff, grp_in;

   logic [COUNT_WIDTH-1:0] tot_near [NUM_SPACERS];
   logic [COUNT_WIDTH-1:0] sh_exact [NUM_SPACERS+1];
   logic [COUNT_WIDTH-1:0] sh_near  [NUM_SPACERS+1];
   logic                   sh_pres  [NUM_SPACERS+1];
   logic [DIGIT_W-1:0]     sh_digit [NUM_SPACERS+1];
   logic [NUM_SPACERS-1:0] pres;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rlen_ff   <= READ_LENGTH_RST;
         thr_ff    <= THRESHOLD_RST;
         orient_ff <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_READ_LENGTH: rlen_ff   <= csr_wdata[LEN_W-1:0];
            REG_THRESHOLD:   thr_ff    <= csr_wdata[THR_W-1:0];
            REG_ORIENTATION: orient_ff <= csr_wdata[0];
            default:         ;
         endcase
      end
   end

   // a report waits while the chain still holds one
   assign req_tready = !(req_tuser && (busy_ff || ctl_ff.report));
   assign accept     = req_tvalid && req_tready;

   // front stage: window shift and read position
   assign new_base = (req_tdata[BASE_W-1:0] > BASE_OTHER) ? BASE_OTHER : req_tdata[BASE_W-1:0];
   assign len      = (rlen_ff > MAX_LEN) ? MAX_LEN : rlen_ff;
   assign pos_n    = pos_ff + 1'b1;

   always_comb begin
      ctl_in = '0;
      pos_in = pos_ff;
      if (accept) begin
         if (req_tuser) begin
            ctl_in.report = 1'b1;
         end else begin
            if (pos_ff < len) begin
               pos_in        = pos_n;
               ctl_in.cmp    = (pos_n >= PLEN);
               ctl_in.commit = (pos_n == len);
            end
            if (req_tlast) begin
               pos_in       = '0;
               ctl_in.clear = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         ctl_ff <= '0;
         for (int i = 0; i < PATTERN_LEN; i++) begin
            win_ff[i] <= '0;
         end
      end else begin
         pos_ff <= pos_in;
         ctl_ff <= ctl_in;
         if (accept && !req_tuser) begin
            for (int i = 0; i < PATTERN_LEN - 1; i++) begin
               win_ff[i] <= win_ff[i+1];
            end
            win_ff[PATTERN_LEN-1] <= new_base;
         end
      end
   end

   // presence of each spacer at snapshot time; octal digits are built in the cell row
   for (genvar s = 0; s < NUM_SPACERS; s++) begin : g_pres
      assign pres[s] = tot_near[s] > {{(COUNT_WIDTH-THR_W){1'b0}}, thr_ff};
   end

   // row of spacer cells, report chain runs toward cell zero
   assign sh_exact[NUM_SPACERS] = '0;
   assign sh_near[NUM_SPACERS]  = '0;
   assign sh_pres[NUM_SPACERS]  = 1'b0;
   assign sh_digit[NUM_SPACERS] = '0;

   for (genvar s = 0; s < NUM_SPACERS; s++) begin : g_cell
      localparam int G = (s / 3) * 3;
      logic [DIGIT_W-1:0] digit;

      always_comb begin
         digit = '0;
         for (int k = 0; k < 3; k++) begin
            if (G + k < NUM_SPACERS) begin
               digit = {digit[DIGIT_W-2:0], pres[G+k]};
            end
         end
      end

      skmc_cell #(
         .IDX         (s),
         .PATTERN_LEN (PATTERN_LEN),
         .COUNT_WIDTH (COUNT_WIDTH)
      ) u_cell (
         .clock       (clock),
         .reset       (reset),
         .win         (win_ff),
         .orient      (orient_ff),
         .ctl         (ctl_ff),
         .shift       (shift),
         .load_pres   (pres[s]),
         .load_digit  (digit),
         .sh_in_exact (sh_exact[s+1]),
         .sh_in_near  (sh_near[s+1]),
         .sh_in_pres  (sh_pres[s+1]),
         .sh_in_digit (sh_digit[s+1]),
         .tot_near    (tot_near[s]),
         .sh_exact    (sh_exact[s]),
         .sh_near     (sh_near[s]),
         .sh_pres     (sh_pres[s]),
         .sh_digit    (sh_digit[s])
      );
   end

   // report drain control
   assign shift = busy_ff && rsp_tready;

   always_comb begin
      busy_in = busy_ff;
      idx_in  = idx_ff;
      grp_in  = grp_ff;
      if (ctl_ff.report) begin
         busy_in = 1'b1;
         idx_in  = '0;
         grp_in  = '0;
      end else if (shift) begin
         idx_in = idx_ff + 1'b1;
         grp_in = (grp_ff == 2'd2) ? 2'd0 : grp_ff + 2'd1;
         if (idx_ff == LAST_IDX) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         idx_ff  <= '0;
         grp_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         idx_ff  <= idx_in;
         grp_ff  <= grp_in;
      end
   end

   // result item from the head of the chain
   assign rsp_tvalid = busy_ff;
   assign rsp_tlast  = (idx_ff == LAST_IDX);
   assign rsp_tdata  = {{(RSP_W-RSP_BITS){1'b0}},
                        ((grp_ff == 2'd2) || (idx_ff == LAST_IDX)),
                        sh_digit[0], sh_pres[0], sh_near[0], sh_exact[0], idx_ff};

endmodule

// ===== rtl/skmc_cell.sv =====
// skmc_cell: one spacer comparator with pending and total counters and
// one stage of the report shift chain; depends on skmc_pkg

module skmc_cell #(
   parameter int IDX         = 0,
   parameter int PATTERN_LEN = skmc_pkg::DEF_PATTERN_LEN,
   parameter int COUNT_WIDTH = skmc_pkg::DEF_COUNT_WIDTH
) (
   input  logic                         clock,
   input  logic                         reset,
   input  skmc_pkg::base_type           win [PATTERN_LEN],
   input  logic                         orient,
   input  skmc_pkg::ctl_type            ctl,
   input  logic                         shift,
   input  logic                         load_pres,
   input  logic [skmc_pkg::DIGIT_W-1:0] load_digit,
   input  logic [COUNT_WIDTH-1:0]       sh_in_exact,
   input  logic [COUNT_WIDTH-1:0]       sh_in_near,
   input  logic                         sh_in_pres,
   input  logic [skmc_pkg::DIGIT_W-1:0] sh_in_digit,
   output logic [COUNT_WIDTH-1:0]       tot_near,
   output logic [COUNT_WIDTH-1:0]       sh_exact,
   output logic [COUNT_WIDTH-1:0]       sh_near,
   output logic                         sh_pres,
   output logic [skmc_pkg::DIGIT_W-1:0] sh_digit
);
   import skmc_pkg::*;

   logic [PATTERN_LEN-1:0] mm;
   logic                   exact_hit, near_hit;
   logic [PEND_W-1:0]      pe_ff, pe_in, pn_ff, pn_in, pe_sum, pn_sum;
   logic [COUNT_WIDTH-1:0] te_ff, te_in, tn_ff, tn_in;
   logic [COUNT_WIDTH:0]   te_add, tn_add;
   logic [COUNT_WIDTH-1:0] she_ff, she_in, shn_ff, shn_in;
   logic                   shp_ff, shp_in;
   logic [DIGIT_W-1:0]     shd_ff, shd_in;

   // per-position mismatch against the selected pattern
   for (genvar j = 0; j < PATTERN_LEN; j++) begin : g_pos
      localparam base_type PD = pattern_code(IDX, j, 1'b0);
      localparam base_type PR = pattern_code(IDX, j, 1'b1);
      assign mm[j] = (win[j] != (orient ? PR : PD));
   end

   // zero or one differing base
   assign exact_hit = ctl.cmp && (mm == '0);
   assign near_hit  = ctl.cmp && ((mm & (mm - 1'b1)) == '0);

   assign pe_sum = pe_ff + {{(PEND_W-1){1'b0}}, exact_hit};
   assign pn_sum = pn_ff + {{(PEND_W-1){1'b0}}, near_hit};
   assign te_add = {1'b0, te_ff} + {{(COUNT_WIDTH+1-PEND_W){1'b0}}, pe_sum};
   assign tn_add = {1'b0, tn_ff} + {{(COUNT_WIDTH+1-PEND_W){1'b0}}, pn_sum};

   // pending and saturating totals
   always_comb begin
      pe_in = (ctl.commit || ctl.clear) ? '0 : pe_sum;
      pn_in = (ctl.commit || ctl.clear) ? '0 : pn_sum;
      te_in = te_ff;
      tn_in = tn_ff;
      if (ctl.commit) begin
         te_in = te_add[COUNT_WIDTH] ? '1 : te_add[COUNT_WIDTH-1:0];
         tn_in = tn_add[COUNT_WIDTH] ? '1 : tn_add[COUNT_WIDTH-1:0];
      end
   end

   // report snapshot and shift toward cell zero
   always_comb begin
      she_in = she_ff;
      shn_in = shn_ff;
      shp_in = shp_ff;
      shd_in = shd_ff;
      if (ctl.report) begin
         she_in = te_ff;
         shn_in = tn_ff;
         shp_in = load_pres;
         shd_in = load_digit;
      end else if (shift) begin
         she_in = sh_in_exact;
         shn_in = sh_in_near;
         shp_in = sh_in_pres;
         shd_in = sh_in_digit;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pe_ff <= '0;
         pn_ff <= '0;
         te_ff <= '0;
         tn_ff <= '0;
      end else begin
         pe_ff <= pe_in;
         pn_ff <= pn_in;
         te_ff <= te_in;
         tn_ff <= tn_in;
      end
   end

   always_ff @(posedge clock) begin
      she_ff <= she_in;
      shn_ff <= shn_in;
      shp_ff <= shp_in;
      shd_ff <= shd_in;
   end

   assign tot_near = tn_ff;
   assign sh_exact = she_ff;
   assign sh_near  = shn_ff;
   assign sh_pres  = shp_ff;
   assign sh_digit = shd_ff;

endmodule

// ===== tb/tb_spacer_kmer_mismatch_counter.sv =====
// testbench for spacer_kmer_mismatch_counter: random and directed reads
// checked against a built-in count predictor; depends on skmc_pkg and the rtl

module tb_spacer_kmer_mismatch_counter;
   timeunit 1ns;
   timeprecision 1ps;
   import skmc_pkg::*;

   localparam int N_SP    = DEF_NUM_SPACERS;
   localparam int K       = DEF_PATTERN_LEN;
   localparam int MAX_LEN = DEF_MAX_READ_LEN;
   localparam logic CMD_BASE   = 1'b0;
   localparam logic CMD_REPORT = 1'b1;
   localparam int IDLE_LIMIT = 20000;

   typedef struct {
      logic [5:0]  idx;
      logic [31:0] exact;
      logic [31:0] near;
      logic        present;
      logic [2:0]  digit;
      logic        digit_valid;
      logic        last;
   } spacer_report_type;

   // spacer count predictor and report checker
   class spacer_count_scoreboard;
      logic [2:0]        win[K];
      int                pos;
      int                pend_exact[N_SP];
      int                pend_near[N_SP];
      longint            tot_exact[N_SP];
      longint            tot_near[N_SP];
      int                read_len;
      int                threshold;
      bit                rev;
      spacer_report_type reports[$];
      int                failures;

      function new();
         foreach (win[i]) win[i] = '0;
         pos = 0;
         foreach (pend_exact[i]) begin
            pend_exact[i] = 0; pend_near[i] = 0; tot_exact[i] = 0; tot_near[i] = 0;
         end
         read_len = READ_LENGTH_RST;
         threshold = THRESHOLD_RST;
         rev = 0;
         failures = 0;
      endfunction

      static function logic [2:0] pat_code(int s, int j, bit r);
         logic [7:0] ch;
         ch = r ? REV_PAT[s][8*(K-1-j) +: 8] : DIR_PAT[s][8*(K-1-j) +: 8];
         case (ch)
            "A": return 3'd0;
            "C": return 3'd1;
            "G": return 3'd2;
            default: return 3'd3;
         endcase
      endfunction

      function void write_reg(logic [1:0] idx, int val);
         case (idx)
            REG_READ_LENGTH: read_len = val & 'h3FF;
            REG_THRESHOLD:   threshold = val & 'hFFFF;
            REG_ORIENTATION: rev = val[0];
            default: ;
         endcase
      endfunction

      function longint sat32(longint a, longint b);
         return (a + b > 64'hFFFFFFFF) ? 64'hFFFFFFFF : a + b;
      endfunction

      // one accepted item: base shifts the window, report queues 43 results
      function void note_item(logic cmd, logic [2:0] b, logic rend);
         int len, diff;
         bit pres[N_SP];
         spacer_report_type r;
         if (cmd == CMD_REPORT) begin
            foreach (pres[s]) pres[s] = tot_near[s] > threshold;
            for (int s = 0; s < N_SP; s++) begin
               r.idx = 6'(s);
               r.exact = 32'(tot_exact[s]);
               r.near = 32'(tot_near[s]);
               r.present = pres[s];
               r.digit = '0;
               for (int k = (s/3)*3; k < (s/3)*3 + 3 && k < N_SP; k++)
                  r.digit = {r.digit[1:0], pres[k]};
               r.digit_valid = (s % 3 == 2) || (s == N_SP-1);
               r.last = (s == N_SP-1);
               reports.push_back(r);
            end
            return;
         end
         len = read_len > MAX_LEN ? MAX_LEN : read_len;
         for (int j = 0; j < K-1; j++) win[j] = win[j+1];
         win[K-1] = b > 4 ? 3'd4 : b;
         if (pos < len) begin
            pos++;
            if (pos >= K) begin
               for (int s = 0; s < N_SP; s++) begin
                  diff = 0;
                  for (int j = 0; j < K; j++)
                     if (win[j] != pat_code(s, j, rev)) diff++;
                  if (diff <= 1) begin
                     pend_near[s] = (pend_near[s] + 1) & 'h3FF;
                     if (diff == 0) pend_exact[s] = (pend_exact[s] + 1) & 'h3FF;
                  end
               end
            end
            // read reached its scan length: commit pending counts
            if (pos == len) begin
               for (int s = 0; s < N_SP; s++) begin
                  tot_exact[s] = sat32(tot_exact[s], pend_exact[s]);
                  tot_near[s] = sat32(tot_near[s], pend_near[s]);
                  pend_exact[s] = 0; pend_near[s] = 0;
               end
            end
         end
         if (rend) begin
            pos = 0;
            foreach (pend_exact[s]) begin pend_exact[s] = 0; pend_near[s] = 0; end
         end
      endfunction

      function void check(logic [79:0] d, logic last);
         spacer_report_type e;
         if (reports.size() == 0) begin
            $error("unexpected result item, spacer_index %0d", d[5:0]);
            failures++;
            return;
         end
         e = reports.pop_front();
         if (d[5:0] != e.idx) begin
            $error("spacer_index exp %0d got %0d", e.idx, d[5:0]); failures++;
         end
         if (d[37:6] != e.exact) begin
            $error("exact_count exp %0d got %0d", e.exact, d[37:6]); failures++;
         end
         if (d[69:38] != e.near) begin
            $error("near_count exp %0d got %0d", e.near, d[69:38]); failures++;
         end
         if (d[70] != e.present) begin
            $error("present exp %0d got %0d", e.present, d[70]); failures++;
         end
         if (d[73:71] != e.digit) begin
            $error("octal_digit exp %0d got %0d", e.digit, d[73:71]); failures++;
         end
         if (d[74] != e.digit_valid) begin
            $error("digit_valid exp %0d got %0d", e.digit_valid, d[74]); failures++;
         end
         if (last != e.last) begin
            $error("last exp %0d got %0d", e.last, last); failures++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;   // base[2:0]
   logic        req_tuser = 0;    // command
   logic        req_tlast = 0;    // read_end
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   // spacer_index, exact_count, near_count, present, octal_digit, digit_valid
   logic [79:0] rsp_tdata;
   logic        rsp_tlast;        // last
   logic        csr_we = 0;
   logic [CSR_ADDR_W-1:0] csr_addr = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   spacer_count_scoreboard sb = new();
   int burst_left = 0;
   int idle_cycles = 0;
   int stall_mode = 0;
   int stall_tick = 0;

   spacer_kmer_mismatch_counter DUT (.*);

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   // result checking and no-progress watchdog
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) sb.check(rsp_tdata, rsp_tlast);
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // receiver stall pattern in randomly chosen modes
   always @(negedge clock) begin
      stall_tick++;
      if (stall_tick % 64 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= $urandom_range(0, 1);
         2: rsp_tready <= (stall_tick % 4 == 0);
         default: rsp_tready <= ($urandom_range(0, 9) != 0);
      endcase
   end

   // one item on the input channel, with burst gaps
   task automatic send_item(logic cmd, logic [2:0] b, logic rend);
      if (burst_left == 0) begin
         repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 8)) @(negedge clock);
         burst_left = $urandom_range(1, 40);
      end
      req_tvalid = 1;
      req_tuser = cmd;
      req_tdata = {5'b0, b};
      req_tlast = rend;
      do @(posedge clock); while (!req_tready);
      sb.note_item(cmd, b, rend);
      burst_left--;
      @(negedge clock);
      req_tvalid = 0;
   endtask

   // a read with an optional spacer copy carrying some substitutions
   task automatic send_read(int len, bit hit, int n_mut);
      logic [2:0] seq[];
      int s, off, j, scan;
      seq = new[len];
      foreach (seq[i]) seq[i] = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(4, 7))
                                                           : 3'($urandom_range(0, 3));
      scan = sb.read_len > MAX_LEN ? MAX_LEN : sb.read_len;
      if (scan > len) scan = len;
      if (hit && len >= K) begin
         s = $urandom_range(0, N_SP-1);
         off = (scan >= K) ? $urandom_range(0, scan - K) : 0;
         for (int i = 0; i < K; i++)
            seq[off+i] = spacer_count_scoreboard::pat_code(s, i, sb.rev);
         repeat (n_mut) begin
            j = $urandom_range(0, K-1);
            seq[off+j] = 3'($urandom_range(0, 7));
         end
      end
      for (int i = 0; i < len; i++) send_item(CMD_BASE, seq[i], i == len-1);
   endtask

   task automatic report();
      send_item(CMD_REPORT, 3'($urandom_range(0, 7)), 1'($urandom_range(0, 1)));
   endtask

   // registers change only once the block has drained
   task automatic write_csr(logic [CSR_ADDR_W-1:0] idx, int val);
      while (sb.reports.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      @(negedge clock);
      csr_we = 1;
      csr_addr = idx;
      csr_wdata = CSR_DATA_W'(val);
      @(negedge clock);
      csr_we = 0;
      sb.write_reg(idx, val);
   endtask

   initial begin
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // reset settings: empty totals, exact hit, unknown bases as a short read
      report();
      send_read(75, 1, 0);
      for (int c = 4; c < 8; c++) send_item(CMD_BASE, 3'(c), c == 7);

      // shorter scan length: near hit, dropped short read, back-to-back reports
      write_csr(REG_READ_LENGTH, 35);
      write_csr(REG_THRESHOLD, 0);
      send_read(35, 1, 1);
      send_read(26, 1, 0);
      report();
      report();

      // reverse-complement patterns
      write_csr(REG_THRESHOLD, 1);
      write_csr(REG_ORIENTATION, 1);
      send_read(35, 1, 0);
      report();

      // scan length below the pattern length, top threshold
      write_csr(REG_READ_LENGTH, 24);
      write_csr(REG_THRESHOLD, 65535);
      write_csr(REG_ORIENTATION, $urandom_range(0, 1));
      send_read(30, 1, 0);
      report();

      while (sb.reports.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (sb.failures == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end
endmodule
